@@ design/assert_macros.svh @@
// Assertion macros for the checker file fwkr_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while out of reset.
`define FWKR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property checked at every edge, reset included.
`define FWKR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ design/fwkr_pkg.sv @@
// Types and constants for the keyed-removal FIFO.
// No dependencies; used by every module of the block.
`default_nettype none

package fwkr_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_NOMATCH = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] entry_handle;
        logic [31:0] entry_key;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [15:0] out_handle;
        logic [31:0] out_key;
        logic [5:0]  count;
    } t_out_word;

    typedef struct packed {
        logic [15:0] handle;
        logic [31:0] key;
    } t_entry;

    // per-cell controls from the sequencer
    typedef struct packed {
        logic load;   // take the pushed entry
        logic shift;  // take the neighbor's entry (close a gap)
        logic probe;  // this cell is under the removal scan
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ design/fifo_with_keyed_removal.sv @@
// Top level of the keyed-removal FIFO: sequencer, fill count, result
// register and the row of fwkr_cell slots. Uses fwkr_pkg.
//
//  channel | valid      | stall      | word
//  --------+------------+------------+------------------------
//  input   | i_in_valid | o_in_stall | i_in_word  (t_in_word)
//  output  | o_out_valid| i_out_stall| o_out_word (t_out_word)
//
// Push, pop, ignored codes and commands on an empty queue: result
// registered at the accepting edge, one cycle a word unless a stalled result holds the input.
// Removal: accepted, then the slots are probed oldest first, up to the fill
// count; the scan walks the cell row one slot a cycle and takes no new command.
// The gap is closed in the cycle of the hit, all later cells shifting at once.
// Reset clears the sequencer state, fill count and result valid; slots are not cleared.
// A stalled result holds the input off only while it is still waiting.
`default_nettype none

module fifo_with_keyed_removal
    import fwkr_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_word o_out_word
);

    t_state      r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_step, n_step;
    logic [31:0] r_key, n_key;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out_word, n_out_word;

    logic        in_acc;
    logic        push_load;
    logic        close;
    logic [IDX_W-1:0] close_pos;
    logic        hit;
    logic        scan_last;

    t_entry      cell_data [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_hit;
    t_entry      push_entry;

    assign push_entry.handle = i_in_word.entry_handle;
    assign push_entry.key    = i_in_word.entry_key;

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign hit       = |cell_hit;
    assign scan_last = (CNT_W'(r_step) + CNT_W'(1)) == r_count;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            t_cell_ctl ctl;
            t_entry    next_entry;

            assign ctl.load  = push_load && (CNT_W'(gi) == r_count);
            assign ctl.shift = close && (IDX_W'(gi) >= close_pos);
            assign ctl.probe = (r_state == S_SCAN) && (IDX_W'(gi) == r_step);

            if (gi == QUEUE_DEPTH - 1) begin : g_last
                assign next_entry = cell_data[gi];
            end else begin : g_mid
                assign next_entry = cell_data[gi+1];
            end

            fwkr_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (ctl),
                .i_push (push_entry),
                .i_next (next_entry),
                .i_key  (r_key),
                .o_entry(cell_data[gi]),
                .o_hit  (cell_hit[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_key       = r_key;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        push_load   = 1'b0;
        close       = 1'b0;
        close_pos   = r_step;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out_valid = 1'b1;
                    n_out_word  = '0;
                    unique case (t_cmd'(i_in_word.cmd))
                        CMD_PUSH: begin
                            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                n_out_word.status = STAT_FULL;
                            end else begin
                                push_load = 1'b1;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                n_out_word.status = STAT_EMPTY;
                            end else begin
                                n_out_word.out_handle = cell_data[0].handle;
                                n_out_word.out_key    = cell_data[0].key;
                                close     = 1'b1;
                                close_pos = '0;
                                n_count   = r_count - CNT_W'(1);
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_out_word.status = STAT_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_SCAN;
                                n_step      = '0;
                                n_key       = i_in_word.entry_key;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_word.count = 6'(n_count);
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_out_word            = '0;
                    n_out_word.out_handle = cell_data[r_step].handle;
                    n_out_word.out_key    = cell_data[r_step].key;
                    close       = 1'b1;
                    close_pos   = r_step;
                    n_count     = r_count - CNT_W'(1);
                    n_out_word.count = 6'(n_count);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else if (scan_last) begin
                    n_out_word        = '0;
                    n_out_word.status = STAT_NOMATCH;
                    n_out_word.count  = 6'(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    n_step = r_step + IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_key      <= n_key;
        r_out_word <= n_out_word;
    end

endmodule

`default_nettype wire

@@ design/fwkr_cell.sv @@
// One queue slot: holds an entry, loads a push, shifts from its neighbor
// and compares its key during a removal scan. Uses fwkr_pkg.
`default_nettype none

module fwkr_cell
    import fwkr_pkg::*;
(
    input  wire       i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_push,
    input  t_entry    i_next,
    input  wire [31:0] i_key,
    output t_entry    o_entry,
    output logic      o_hit
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_push;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = i_ctl.probe && (r_entry.key == i_key);

endmodule

`default_nettype wire

@@ design/fwkr_checker.sv @@
// Port-level checks for fifo_with_keyed_removal, bound to the top level.
// Uses fwkr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fwkr_checker
    import fwkr_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_stall,
    input t_in_word  i_in_word,
    input wire       o_out_valid,
    input wire       i_out_stall,
    input t_out_word o_out_word
);

    // a result waiting downstream must hold still
    `FWKR_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word), "stalled result word changed")

    // a full report only comes with a full queue
    `FWKR_ASSERT(a_full_count, i_clk, i_rst_n, o_out_valid && o_out_word.status == STAT_FULL |-> o_out_word.count == 6'(QUEUE_DEPTH), "full status with short count")

    // failed commands return no entry
    `FWKR_ASSERT(a_fail_zero, i_clk, i_rst_n, o_out_valid && o_out_word.status != STAT_OK |-> o_out_word.out_handle == '0 && o_out_word.out_key == '0, "failed command returned data")

    // empty report means nothing is held
    `FWKR_ASSERT(a_empty_count, i_clk, i_rst_n, o_out_valid && o_out_word.status == STAT_EMPTY |-> o_out_word.count == '0, "empty status with nonzero count")

    // no result right out of reset
    `FWKR_ASSERT_ALWAYS(a_rst_quiet, i_clk, $past(!i_rst_n) |-> !o_out_valid, "result valid after reset")

endmodule

bind fifo_with_keyed_removal fwkr_checker u_fwkr_checker (.*);

`default_nettype wire

@@ tb/fifo_with_keyed_removal_tb.sv @@
// Self-checking testbench for the keyed-removal FIFO: push, pop and keyed removal
// are checked against a queue mirror of the block. Depends on fwkr_pkg.
`timescale 1ns / 100ps

import fwkr_pkg::*;

// Mirror of the queue contents plus the words the block still owes.
class queue_mirror;
    t_entry      mirror_slots[$];
    t_out_word   awaited_results[$];
    int unsigned fail_count;

    function new();
        fail_count = 0;
    endfunction

    function int depth();
        return mirror_slots.size();
    endfunction

    function logic [31:0] key_at(int idx);
        return mirror_slots[idx].key;
    endfunction

    function int awaited();
        return awaited_results.size();
    endfunction

    // Applies one accepted command and queues the word it should produce.
    function void note_command(t_in_word w);
        t_out_word r;
        int        hit;
        r = '0;
        r.status = STAT_OK;
        hit = -1;
        case (w.cmd)
            CMD_PUSH: begin
                if (mirror_slots.size() >= QUEUE_DEPTH)
                    r.status = STAT_FULL;
                else
                    mirror_slots.push_back('{handle: w.entry_handle, key: w.entry_key});
            end
            CMD_POP: begin
                if (mirror_slots.size() == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.out_handle = mirror_slots[0].handle;
                    r.out_key    = mirror_slots[0].key;
                    void'(mirror_slots.pop_front());
                end
            end
            CMD_REMOVE: begin
                if (mirror_slots.size() == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    // oldest matching entry wins
                    for (int i = 0; i < mirror_slots.size(); i++) begin
                        if (hit < 0 && mirror_slots[i].key == w.entry_key)
                            hit = i;
                    end
                    if (hit < 0) begin
                        r.status = STAT_NOMATCH;
                    end else begin
                        r.out_handle = mirror_slots[hit].handle;
                        r.out_key    = mirror_slots[hit].key;
                        mirror_slots.delete(hit);
                    end
                end
            end
            default: ; // unused code: no change
        endcase
        r.count = 6'(mirror_slots.size());
        awaited_results.push_back(r);
    endfunction

    function void report_field(string field, longint unsigned exp_v,
                               longint unsigned got_v);
        fail_count++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, got_v);
    endfunction

    function void check_result(t_out_word got);
        t_out_word exp_w;
        if (awaited_results.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected word, expected none, got %h", $time, got);
            return;
        end
        exp_w = awaited_results.pop_front();
        if (got.status !== exp_w.status)
            report_field("status", exp_w.status, got.status);
        if (got.out_handle !== exp_w.out_handle)
            report_field("out_handle", exp_w.out_handle, got.out_handle);
        if (got.out_key !== exp_w.out_key)
            report_field("out_key", exp_w.out_key, got.out_key);
        if (got.count !== exp_w.count)
            report_field("count", exp_w.count, got.count);
    endfunction
endclass

module fifo_with_keyed_removal_tb;

    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          DRAIN_WAIT  = 2 * QUEUE_DEPTH + 8;
    localparam int          BLOCKS      = 22;
    localparam int          BLOCK_LEN   = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_word    in_word = '0;
    logic        out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_word   o_out_word;

    int          in_gap_max = 0;
    int          out_gap_max = 0;
    int unsigned cycles = 0;
    logic [31:0] key_pool[8];
    queue_mirror mirror = new();

    fifo_with_keyed_removal u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // both channels sampled at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !o_in_stall)
                mirror.note_command(in_word);
            if (o_out_valid && !out_stall)
                mirror.check_result(o_out_word);
        end
    end

    // result side: random stall before each word, then take it
    initial begin
        int n;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            n = $urandom_range(0, out_gap_max);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (o_out_valid !== 1'b1);
            @(negedge clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(t_in_word w);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (o_in_stall);
        @(negedge clk);
    endtask

    task automatic issue(logic [1:0] cmd, logic [15:0] handle, logic [31:0] key);
        t_in_word w;
        w.cmd          = cmd;
        w.entry_handle = handle;
        w.entry_key    = key;
        send_word(w);
    endtask

    function automatic void refresh_keys();
        for (int k = 0; k < 8; k++) begin
            case ($urandom_range(0, 7))
                0:       key_pool[k] = 32'h0;
                1:       key_pool[k] = 32'hFFFF_FFFF;
                default: key_pool[k] = $urandom();
            endcase
        end
    endfunction

    function automatic t_in_word random_word(int push_pct);
        t_in_word w;
        int       roll;
        roll           = $urandom_range(0, 99);
        w.entry_handle = $urandom();
        w.entry_key    = ($urandom_range(0, 9) < 6) ? key_pool[$urandom_range(0, 7)]
                                                    : $urandom();
        if (roll < 3) begin
            w.cmd = CMD_UNUSED;
        end else if (roll < push_pct) begin
            w.cmd = CMD_PUSH;
        end else if (roll < push_pct + (100 - push_pct) / 2) begin
            w.cmd = CMD_POP;
        end else begin
            w.cmd = CMD_REMOVE;
            // half the time, hit a live entry, anywhere in the queue
            if (mirror.depth() > 0 && $urandom_range(0, 1))
                w.entry_key = mirror.key_at($urandom_range(0, mirror.depth() - 1));
        end
        return w;
    endfunction

    initial begin
        int push_pct;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty cases, field extremes, duplicate keys, head/middle/tail hits
        issue(CMD_POP,    16'h0,    32'h0);
        issue(CMD_REMOVE, 16'hFFFF, 32'h0);
        issue(CMD_UNUSED, 16'h0,    32'h0);
        issue(CMD_PUSH,   16'h0,    32'h0);
        issue(CMD_PUSH,   16'hFFFF, 32'hFFFF_FFFF);
        issue(CMD_PUSH,   16'h1234, 32'hA5A5_0001);
        issue(CMD_PUSH,   16'h5678, 32'hA5A5_0001);
        issue(CMD_PUSH,   16'h9ABC, 32'h5A5A_0002);
        issue(CMD_REMOVE, 16'h0,    32'hA5A5_0001);
        issue(CMD_REMOVE, 16'hFFFF, 32'h0BAD_0003);
        issue(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        issue(CMD_REMOVE, 16'h0,    32'h5A5A_0002);
        issue(CMD_POP,    16'hFFFF, 32'hFFFF_FFFF);
        issue(CMD_REMOVE, 16'h0,    32'hFFFF_FFFF);
        issue(CMD_POP,    16'h0,    32'h0);
        issue(CMD_POP,    16'h0,    32'h0);
        issue(CMD_REMOVE, 16'h0,    32'hA5A5_0001);

        // random blocks: push-heavy toward full, drain-heavy toward empty, or mixed
        for (int b = 0; b < BLOCKS; b++) begin
            refresh_keys();
            case (b % 3)
                0:       push_pct = 80;
                1:       push_pct = 50;
                default: push_pct = 20;
            endcase
            in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 6;
            out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            for (int i = 0; i < BLOCK_LEN; i++)
                send_word(random_word(push_pct));
        end
        in_valid <= 1'b0;

        while (mirror.awaited() > 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mirror.fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ fifo_with_keyed_removal.f @@
+incdir+design
design/fwkr_pkg.sv
design/fwkr_cell.sv
design/fifo_with_keyed_removal.sv
design/fwkr_checker.sv
tb/fifo_with_keyed_removal_tb.sv
